>>> sv/bpcb_pkg.sv
package bpcb_pkg;

    // Destination pixel formats
    localparam logic [1:0] FMT_RGBA32 = 2'd0;
    localparam logic [1:0] FMT_RGB24  = 2'd1;
    localparam logic [1:0] FMT_RGB565 = 2'd2;

    // Configuration register indexes
    localparam logic CFG_DEST_FORMAT  = 1'b0;
    localparam logic CFG_BLEND_ENABLE = 1'b1;

    // Alpha codes with a shortcut
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    // Channel lanes: red, green, blue, alpha
    localparam int LANES = 4;

    typedef logic [LANES-1:0][7:0]  lane8_t;
    typedef logic [LANES-1:0][15:0] lane16_t;

    // What the last stage does with an item
    typedef enum logic [1:0] {
        MODE_KEEP,
        MODE_COPY,
        MODE_MIX
    } mode_t;

    // Control and pass-through payload that travels with each item
    typedef struct packed {
        mode_t       mode;
        logic [1:0]  fmt;
        logic [31:0] src;
        logic [31:0] dst;
    } item_t;

endpackage

>>> sv/bpcb_unpack.sv
module bpcb_unpack
    import bpcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] in_data,
    input  logic [1:0]  dest_format,
    input  logic        blend_enable,
    output logic        valid_reg,
    output item_t       item_reg,
    output lane8_t      src_lane_reg,
    output lane8_t      dst_lane_reg,
    output logic [7:0]  alpha_reg
);

    logic [7:0]  src_red;
    logic [7:0]  src_green;
    logic [7:0]  src_blue;
    logic [7:0]  src_alpha;
    logic [31:0] dst_word;
    item_t       item_next;
    lane8_t      src_lane_next;
    lane8_t      dst_lane_next;

    assign src_red   = in_data[7:0];
    assign src_green = in_data[15:8];
    assign src_blue  = in_data[23:16];
    assign src_alpha = in_data[31:24];
    assign dst_word  = in_data[63:32];

    // Decide the path and line up the destination channels
    always_comb
    begin
        item_next.fmt  = dest_format;
        item_next.src  = {src_alpha, src_blue, src_green, src_red};
        item_next.dst  = dst_word;
        item_next.mode = MODE_KEEP;
        src_lane_next  = {ALPHA_OPAQUE, src_blue, src_green, src_red};
        dst_lane_next  = {dst_word[31:24], dst_word[23:16], dst_word[15:8], dst_word[7:0]};
        case (dest_format)
            FMT_RGBA32:
            begin
                if (!blend_enable || src_alpha == ALPHA_OPAQUE)
                    item_next.mode = MODE_COPY;
                else if (src_alpha != ALPHA_CLEAR)
                    item_next.mode = MODE_MIX;
            end
            FMT_RGB24:
            begin
                item_next.mode = blend_enable ? MODE_MIX : MODE_COPY;
            end
            FMT_RGB565:
            begin
                // Widen the 565 fields by a left shift
                dst_lane_next = {8'h00, {dst_word[4:0], 3'b000},
                                 {dst_word[10:5], 2'b00}, {dst_word[15:11], 3'b000}};
                if (!blend_enable || src_alpha == ALPHA_OPAQUE)
                    item_next.mode = MODE_COPY;
                else if (src_alpha != ALPHA_CLEAR)
                    item_next.mode = MODE_MIX;
            end
            default:
            begin
                item_next.mode = MODE_KEEP;
            end
        endcase
    end

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg     <= item_next;
            src_lane_reg <= src_lane_next;
            dst_lane_reg <= dst_lane_next;
            alpha_reg    <= src_alpha;
        end
    end

endmodule

>>> sv/bpcb_mix.sv
module bpcb_mix
    import bpcb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  item_t      in_item,
    input  lane8_t     src_lane,
    input  lane8_t     dst_lane,
    input  logic [7:0] alpha,
    output logic       valid_reg,
    output item_t      item_reg,
    output lane8_t     mix_lane_reg
);

    // Exact floor(x / 255) for x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        begin
            sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
            return sum[15:8];
        end
    endfunction

    logic    prod_valid_reg;
    item_t   prod_item_reg;
    lane16_t prod_lane_reg;
    lane16_t prod_lane_next;
    lane8_t  mix_lane_next;
    logic [7:0] alpha_inv;

    assign alpha_inv = ALPHA_OPAQUE - alpha;

    // Weighted sum per lane: s*a + d*(255-a)
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            prod_lane_next[i] = 16'({8'd0, src_lane[i]} * {8'd0, alpha})
                              + 16'({8'd0, dst_lane[i]} * {8'd0, alpha_inv});
        end
    end

    // Scale back by 1/255
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            mix_lane_next[i] = div255(prod_lane_reg[i]);
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= in_valid;
            valid_reg      <= prod_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_item_reg <= in_item;
            prod_lane_reg <= prod_lane_next;
            item_reg      <= prod_item_reg;
            mix_lane_reg  <= mix_lane_next;
        end
    end

endmodule

>>> sv/bpcb_pack.sv
module bpcb_pack
    import bpcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  item_t       in_item,
    input  lane8_t      mix_lane,
    output logic        valid_reg,
    output logic [31:0] word_reg,
    output logic        write_reg
);

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        begin
            return {r[7:3], g[7:2], b[7:3]};
        end
    endfunction

    logic [31:0] word_next;
    logic        write_next;
    logic [7:0]  sr;
    logic [7:0]  sg;
    logic [7:0]  sb;
    logic [7:0]  sa;

    assign sr = in_item.src[7:0];
    assign sg = in_item.src[15:8];
    assign sb = in_item.src[23:16];
    assign sa = in_item.src[31:24];

    // Pack the result into the destination layout
    always_comb
    begin
        word_next  = in_item.dst;
        write_next = 1'b0;
        case (in_item.mode)
            MODE_COPY:
            begin
                write_next = 1'b1;
                case (in_item.fmt)
                    FMT_RGBA32: word_next = {sa, sb, sg, sr};
                    FMT_RGB24:  word_next = {8'h00, sb, sg, sr};
                    FMT_RGB565: word_next = {16'h0000, pack565(sr, sg, sb)};
                    default:    write_next = 1'b0;
                endcase
            end
            MODE_MIX:
            begin
                write_next = 1'b1;
                case (in_item.fmt)
                    FMT_RGBA32: word_next = {mix_lane[3], mix_lane[2], mix_lane[1], mix_lane[0]};
                    FMT_RGB24:  word_next = {8'h00, mix_lane[2], mix_lane[1], mix_lane[0]};
                    FMT_RGB565:
                        word_next = {16'h0000, pack565(mix_lane[0], mix_lane[1], mix_lane[2])};
                    default:    write_next = 1'b0;
                endcase
            end
            default:
            begin
                word_next  = in_item.dst;
                write_next = 1'b0;
            end
        endcase
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg  <= word_next;
            write_reg <= write_next;
        end
    end

endmodule

>>> sv/blit_pixel_convert_blend.sv
// Throughput: one pixel per cycle; decode, multiply-add, divide-by-255 and pack
// stages each hold one pixel, and the whole pipe holds while the output stalls.
// Reset (rst_n, asynchronous, active low) clears all stage valids and sets
// dest_format and blend_enable to 0 (RGBA32, plain copy).
module blit_pixel_convert_blend
    import bpcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [1:0]  cfg_wdata,
    // Source stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // src_red, src_green, src_blue, src_alpha, dst_word
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // new_word
    output logic        m_tuser    // write_enable
);

    logic [1:0] dest_format_reg;
    logic       blend_enable_reg;
    logic       en;

    logic       s1_valid;
    item_t      s1_item;
    lane8_t     s1_src_lane;
    lane8_t     s1_dst_lane;
    logic [7:0] s1_alpha;

    logic       s3_valid;
    item_t      s3_item;
    lane8_t     s3_mix_lane;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_format_reg  <= FMT_RGBA32;
            blend_enable_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_DEST_FORMAT:  dest_format_reg  <= cfg_wdata;
                CFG_BLEND_ENABLE: blend_enable_reg <= cfg_wdata[0];
                default:          dest_format_reg  <= dest_format_reg;
            endcase
        end
    end

    // Advance the whole pipe unless the output holds an untaken result
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    bpcb_unpack u_unpack (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s_tvalid),
        .in_data      (s_tdata),
        .dest_format  (dest_format_reg),
        .blend_enable (blend_enable_reg),
        .valid_reg    (s1_valid),
        .item_reg     (s1_item),
        .src_lane_reg (s1_src_lane),
        .dst_lane_reg (s1_dst_lane),
        .alpha_reg    (s1_alpha)
    );

    bpcb_mix u_mix (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s1_valid),
        .in_item      (s1_item),
        .src_lane     (s1_src_lane),
        .dst_lane     (s1_dst_lane),
        .alpha        (s1_alpha),
        .valid_reg    (s3_valid),
        .item_reg     (s3_item),
        .mix_lane_reg (s3_mix_lane)
    );

    bpcb_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid),
        .in_item   (s3_item),
        .mix_lane  (s3_mix_lane),
        .valid_reg (m_tvalid),
        .word_reg  (m_tdata),
        .write_reg (m_tuser)
    );

endmodule

>>> sv/bpcb_checker.sv
module bpcb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // No result shows once reset has been sampled low
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Input side takes a transfer whenever the output side is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with free output");

    // A transferred pixel reaches the output when m_tready holds while it passes through the pipe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("pixel lost in pipe");

endmodule

bind blit_pixel_convert_blend bpcb_checker u_bpcb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
